FILE: hw/rtl/lgf_pkg.sv
// Shared types and constants of the lidar gap finder.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none
package lgf_pkg;

   localparam int IDX_W       = 12;
   localparam int LEN_W       = 13;
   localparam int RANGE_W     = 16;
   localparam int COUNT_W     = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;

   localparam int MAX_SAMPLES_DEFAULT = 4096;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [IDX_W-1:0]   WINDOW_START_RESET = 12'd360;
   localparam logic [IDX_W-1:0]   WINDOW_END_RESET   = 12'd720;
   localparam logic [RANGE_W-1:0] THRESHOLD_RESET    = 16'd3000;
   localparam logic [LEN_W-1:0]   MIN_GAP_LEN_RESET  = 13'd40;
   localparam logic [IDX_W-1:0]   TARGET_INDEX_RESET = 12'd540;

   localparam logic [LEN_W-1:0]   RUN_LEN_MAX = {LEN_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_START = 3'd0,
      CSR_WINDOW_END   = 3'd1,
      CSR_THRESHOLD    = 3'd2,
      CSR_MIN_GAP_LEN  = 3'd3,
      CSR_TARGET_INDEX = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [IDX_W-1:0]   window_start;
      logic [IDX_W-1:0]   window_end;
      logic [RANGE_W-1:0] range_threshold_mm;
      logic [LEN_W-1:0]   min_gap_len;
      logic [IDX_W-1:0]   target_index;
   } cfg_type;

   // one classified sample as it travels from front to back
   typedef struct packed {
      logic             is_free;
      logic             last;
      logic [IDX_W-1:0] index;
   } sample_type;

endpackage
`default_nettype wire

FILE: hw/rtl/lgf_front.sv
// Front end: accepts range samples, numbers them and classifies each as free or not.
// Depends on lgf_pkg.
`default_nettype none
module lgf_front
   import lgf_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [RANGE_W-1:0] range_mm,
   input  wire logic               last_sample,
   input  wire logic               q_space,
   output logic                    q_push,
   output sample_type              q_item
);

   // index wraps at the smaller of the scan length and the 12-bit limit
   localparam int LAST_IDX = (MAX_SAMPLES > (1 << IDX_W)) ? ((1 << IDX_W) - 1)
                                                          : (MAX_SAMPLES - 1);

   logic [IDX_W-1:0] sample_index_ff, sample_index_in;
   logic             in_window;

   assign req_tready = q_space;
   assign q_push     = req_tvalid && q_space;

   always_comb begin
      in_window      = (sample_index_ff >= cfg.window_start) &&
                       (sample_index_ff <= cfg.window_end);
      q_item.is_free = in_window && (range_mm > cfg.range_threshold_mm);
      q_item.last    = last_sample;
      q_item.index   = sample_index_ff;
   end

   always_comb begin
      sample_index_in = sample_index_ff;
      if (q_push) begin
         if (last_sample || sample_index_ff == IDX_W'(LAST_IDX)) begin
            sample_index_in = '0;
         end else begin
            sample_index_in = sample_index_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
      end else begin
         sample_index_ff <= sample_index_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/lgf_queue.sv
// Short queue of classified samples between front and back end.
// Depends on lgf_pkg.
`default_nettype none
module lgf_queue
   import lgf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire sample_type push_item,
   output logic            space,
   output logic            valid,
   input  wire logic       pop_ready,
   output sample_type      item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sample_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign space = (count_ff != CNT_W'(DEPTH));
   assign valid = (count_ff != '0);
   assign item  = entry_ff[rd_ptr_ff];
   assign pop   = valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/lgf_back.sv
// Back end: tracks free runs, judges closed runs as gaps, keeps the best midpoint
// and holds the per-scan result in an output register. Depends on lgf_pkg.
`default_nettype none
module lgf_back
   import lgf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        q_valid,
   input  wire sample_type  q_item,
   output logic             q_ready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic             gap_found,
   output logic [IDX_W-1:0] best_mid_index,
   output logic [COUNT_W-1:0] gap_count
);

   logic [LEN_W-1:0]   run_len_ff, run_len_in;
   logic [IDX_W-1:0]   run_end_ff, run_end_in;
   logic [IDX_W-1:0]   best_mid_ff, best_mid_in;
   logic [LEN_W-1:0]   best_diff_ff, best_diff_in;
   logic [COUNT_W-1:0] gaps_ff, gaps_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff;
   logic [IDX_W-1:0]   rsp_mid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic               pop;
   logic [LEN_W-1:0]   ext_len, close_len, need, len_m1;
   logic [IDX_W-1:0]   close_end, half, mid, diff;
   logic               do_close, qualify, better;
   logic [IDX_W-1:0]   best_mid_next;
   logic [LEN_W-1:0]   best_diff_next;
   logic [COUNT_W-1:0] gaps_next;

   // a last item may only leave the queue when the result register is free or is being read
   assign q_ready = !q_item.last || !rsp_valid_ff || rsp_tready;
   assign pop     = q_valid && q_ready;

   // a free last sample extends the run first, then the run is closed
   always_comb begin
      ext_len   = (run_len_ff == RUN_LEN_MAX) ? run_len_ff : run_len_ff + LEN_W'(1);
      close_len = q_item.is_free ? ext_len : run_len_ff;
      close_end = q_item.is_free ? q_item.index : run_end_ff;
      do_close  = !q_item.is_free || q_item.last;
      need      = (cfg.min_gap_len == '0) ? LEN_W'(1) : cfg.min_gap_len;
      qualify   = do_close && (close_len != '0) && (close_len >= need);
      len_m1    = close_len - LEN_W'(1);
      half      = len_m1[LEN_W-1:1];
      mid       = close_end - half;
      diff      = (mid >= cfg.target_index) ? mid - cfg.target_index
                                            : cfg.target_index - mid;
      better    = LEN_W'(diff) < best_diff_ff;

      best_mid_next  = best_mid_ff;
      best_diff_next = best_diff_ff;
      gaps_next      = gaps_ff;
      if (qualify) begin
         if (better) begin
            best_mid_next  = mid;
            best_diff_next = LEN_W'(diff);
         end
         if (gaps_ff != COUNT_MAX) begin
            gaps_next = gaps_ff + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      run_len_in   = run_len_ff;
      run_end_in   = run_end_ff;
      best_mid_in  = best_mid_ff;
      best_diff_in = best_diff_ff;
      gaps_in      = gaps_ff;
      if (pop) begin
         if (q_item.last) begin
            run_len_in   = '0;
            run_end_in   = '0;
            best_mid_in  = '0;
            best_diff_in = RUN_LEN_MAX;
            gaps_in      = '0;
         end else begin
            run_len_in   = q_item.is_free ? ext_len : '0;
            run_end_in   = close_end;
            best_mid_in  = best_mid_next;
            best_diff_in = best_diff_next;
            gaps_in      = gaps_next;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && q_item.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_len_ff   <= '0;
         run_end_ff   <= '0;
         best_mid_ff  <= '0;
         best_diff_ff <= RUN_LEN_MAX;
         gaps_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_len_ff   <= run_len_in;
         run_end_ff   <= run_end_in;
         best_mid_ff  <= best_mid_in;
         best_diff_ff <= best_diff_in;
         gaps_ff      <= gaps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && q_item.last) begin
         rsp_found_ff <= (gaps_next != '0);
         rsp_mid_ff   <= (gaps_next != '0) ? best_mid_next : '0;
         rsp_count_ff <= gaps_next;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign gap_found      = rsp_found_ff;
   assign best_mid_index = rsp_mid_ff;
   assign gap_count      = rsp_count_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/lidar_gap_finder.sv
// lidar_gap_finder: finds the free gap in a lidar scan closest to a target direction.
// Input channel req_*: one range sample (mm) per item in scan order, req_tlast on the
// final sample of a scan. Sample indices are counted internally from 0.
// Result channel rsp_*: one item per scan, sent after the sample marked tlast:
// gap found flag, best gap midpoint index and saturating gap count.
// Config channel csr_*: five registers (window start/end, range threshold, minimum
// gap length, target index); write only while the block is idle. Always ready.
// Throughput: one sample per cycle unless stalled. The front end classifies a sample
// on accept, a two-entry queue carries it to the back end, which registers its
// run/best-gap update. Result: the last sample leaves the queue and sets the registered
// rsp_tvalid, unless an earlier result still waits in the output register.
// Stall: while a result waits, samples keep flowing until the next last sample
// reaches the head of the queue; then the queue fills and req_tready drops.
// Reset (synchronous, active high): registers take their defaults, scan state and
// sample index clear, the queue empties and no result is pending.
// Depends on lgf_pkg, lgf_front, lgf_queue and lgf_back.
`default_nettype none
module lidar_gap_finder
   import lgf_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [RANGE_W-1:0]     req_tdata,   // [15:0] range_mm
   input  wire logic                   req_tlast,   // last_sample
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [11:0] best_mid_index, [23:12] gap_count
   output logic                        rsp_tuser,   // gap_found
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type            cfg_ff, cfg_in;
   logic               q_space, q_push, q_valid, q_ready;
   sample_type         push_item, q_item;
   logic               gap_found;
   logic [IDX_W-1:0]   best_mid_index;
   logic [COUNT_W-1:0] gap_count;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_START: cfg_in.window_start       = csr_data[IDX_W-1:0];
            CSR_WINDOW_END:   cfg_in.window_end         = csr_data[IDX_W-1:0];
            CSR_THRESHOLD:    cfg_in.range_threshold_mm = csr_data[RANGE_W-1:0];
            CSR_MIN_GAP_LEN:  cfg_in.min_gap_len        = csr_data[LEN_W-1:0];
            CSR_TARGET_INDEX: cfg_in.target_index       = csr_data[IDX_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_start       <= WINDOW_START_RESET;
         cfg_ff.window_end         <= WINDOW_END_RESET;
         cfg_ff.range_threshold_mm <= THRESHOLD_RESET;
         cfg_ff.min_gap_len        <= MIN_GAP_LEN_RESET;
         cfg_ff.target_index       <= TARGET_INDEX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lgf_front #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .range_mm    (req_tdata),
      .last_sample (req_tlast),
      .q_space     (q_space),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   lgf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .space     (q_space),
      .valid     (q_valid),
      .pop_ready (q_ready),
      .item      (q_item)
   );

   lgf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_ready        (q_ready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .gap_found      (gap_found),
      .best_mid_index (best_mid_index),
      .gap_count      (gap_count)
   );

   assign rsp_tdata = {gap_count, best_mid_index};
   assign rsp_tuser = gap_found;

`ifndef ASSERT_OFF
   // a new result only follows a last item leaving the queue
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(q_valid && q_ready && q_item.last))
      else $error("result raised without a last item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == (rsp_tdata[RSP_DATA_W-1:IDX_W] != '0)))
      else $error("gap flag disagrees with gap count");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[IDX_W-1:0] == '0))
      else $error("midpoint not zero when no gap found");
`endif

endmodule
`default_nettype wire
